// ----- design/acml_pkg.sv -----
`default_nettype none

package acml_pkg;

   localparam int ACML_CYCLE_DEPTH = 512;
   localparam int SAMPLE_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POS_THRESH  = 2'd0,
      REG_NEG_THRESH  = 2'd1,
      REG_DIFF_LIMIT  = 2'd2,
      REG_EXCESS_LIMIT = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_WAIT_NEG  = 3'd1,
      PH_WAIT_POS  = 3'd2,
      PH_FIRST_POS = 3'd3,
      PH_FIRST_NEG = 3'd4,
      PH_DET_POS   = 3'd5,
      PH_DET_NEG   = 3'd6
   } phase_type;

   localparam logic signed [SAMPLE_W-1:0] POS_THRESH_RESET = 16'sd1000;
   localparam logic signed [SAMPLE_W-1:0] NEG_THRESH_RESET = -16'sd1000;
   localparam logic [SAMPLE_W-1:0] DIFF_LIMIT_RESET = 16'd2000;
   localparam logic [SAMPLE_W-1:0] EXCESS_LIMIT_RESET = 16'd8;
   localparam logic [SAMPLE_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ----- design/acml_ram.sv -----
`default_nettype none

module acml_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/ac_mains_loss_detector.sv -----
`default_nettype none

// Channel | Dir | Handshake              | Payload
// req     | in  | req_tvalid/req_tready  | tdata: voltage_sample, ac_ok
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: loss_flag, last_difference
// csr     | in  | csr_valid/csr_ready    | csr_index, csr_wdata
//
// One item per cycle while rsp is not stalled; each result is held in the compare
// stage and then the result register. The rate is set by the sample store: a read
// at accept, write-back as it leaves, the new entry forwarded to a following read.
// Reset is synchronous; store entries never written since reset read as zero
// through a fill count, so no clearing pass runs.
// A stalled rsp holds the result register and the item in the compare stage.

module ac_mains_loss_detector
   import acml_pkg::*;
#(
   parameter int CYCLE_DEPTH = ACML_CYCLE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] voltage_sample, [16] ac_ok, [23:17] zero
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] loss_flag, [16:1] last_difference, [23:17] zero
   output logic      [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(CYCLE_DEPTH);
   localparam int PW = $clog2(CYCLE_DEPTH + 1);
   localparam logic [PW-1:0] DEPTH_P = PW'(CYCLE_DEPTH);

   // configuration
   logic signed [SAMPLE_W-1:0] pos_thresh_ff;
   logic signed [SAMPLE_W-1:0] neg_thresh_ff;
   logic [SAMPLE_W-1:0] diff_limit_ff;
   logic [SAMPLE_W-1:0] excess_limit_ff;

   // architectural state
   phase_type phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic [SAMPLE_W-1:0] cnt_ff, cnt_in;
   logic loss_ff, loss_in;
   logic [SAMPLE_W-1:0] diff_ff, diff_in;

   // compare stage
   logic s1_valid_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic s1_ok_ff;
   logic fwd_hit_ff;
   logic [SAMPLE_W-1:0] fwd_data_ff;

   // result register
   logic rsp_valid_ff;
   logic rsp_loss_ff;
   logic [SAMPLE_W-1:0] rsp_diff_ff;

   logic req_accept;
   logic fire;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0] stored;
   logic above, below;
   logic overrun, over, trip, fail;
   logic step_record, step_compare;
   logic signed [SAMPLE_W:0] delta;
   logic [SAMPLE_W:0] delta_abs;
   logic [SAMPLE_W-1:0] abs_diff;
   logic [SAMPLE_W-1:0] cnt_inc, cnt_dec;

   assign fire = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_thresh_ff <= POS_THRESH_RESET;
         neg_thresh_ff <= NEG_THRESH_RESET;
         diff_limit_ff <= DIFF_LIMIT_RESET;
         excess_limit_ff <= EXCESS_LIMIT_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_POS_THRESH:   pos_thresh_ff <= csr_wdata;
            REG_NEG_THRESH:   neg_thresh_ff <= csr_wdata;
            REG_DIFF_LIMIT:   diff_limit_ff <= csr_wdata;
            REG_EXCESS_LIMIT: excess_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // store reads as zero at or above the fill mark; forward a same-address write
   assign stored = fwd_hit_ff ? fwd_data_ff :
                   (pos_ff < fill_ff) ? rd_data : '0;

   assign above = s1_sample_ff > pos_thresh_ff;
   assign below = s1_sample_ff < neg_thresh_ff;
   assign overrun = pos_ff >= DEPTH_P;
   assign delta = {stored[SAMPLE_W-1], stored} - {s1_sample_ff[SAMPLE_W-1], s1_sample_ff};
   assign delta_abs = delta[SAMPLE_W] ? (SAMPLE_W+1)'(-delta) : delta;
   assign abs_diff = delta_abs[SAMPLE_W-1:0];
   assign over = abs_diff > diff_limit_ff;
   assign cnt_inc = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign cnt_dec = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
   assign trip = over && (cnt_inc > excess_limit_ff);
   assign step_record = (phase_ff == PH_FIRST_POS) || (phase_ff == PH_FIRST_NEG);
   assign step_compare = (phase_ff == PH_DET_POS) || (phase_ff == PH_DET_NEG);
   assign fail = ((step_record || step_compare) && overrun)
              || (step_compare && !overrun && trip);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_WAIT_NEG:  if (below) phase_in = PH_WAIT_POS;
            PH_WAIT_POS:  if (above) phase_in = PH_FIRST_POS;
            PH_FIRST_POS: begin
               if (fail) phase_in = PH_IDLE;
               else if (below) phase_in = PH_FIRST_NEG;
            end
            PH_FIRST_NEG: begin
               if (fail) phase_in = PH_IDLE;
               else if (above) phase_in = PH_DET_POS;
            end
            PH_DET_POS: begin
               if (fail) phase_in = PH_IDLE;
               else if (below) phase_in = PH_DET_NEG;
            end
            PH_DET_NEG: begin
               if (fail) phase_in = PH_IDLE;
               else if (above) phase_in = PH_DET_POS;
            end
            default: phase_in = (above && s1_ok_ff) ? PH_WAIT_NEG : PH_IDLE;
         endcase
      end
   end

   // datapath and store write-back
   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      loss_in = loss_ff;
      diff_in = diff_ff;
      wr_en = 1'b0;
      if (fire) begin
         case (phase_ff)
            PH_WAIT_NEG, PH_WAIT_POS: ;
            PH_FIRST_POS, PH_FIRST_NEG, PH_DET_POS, PH_DET_NEG: begin
               if (fail) begin
                  pos_in = '0;
                  cnt_in = '0;
                  loss_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  pos_in = pos_ff + 1'b1;
                  if (step_compare) begin
                     cnt_in = over ? cnt_inc : cnt_dec;
                     diff_in = abs_diff;
                  end
                  if ((phase_ff == PH_FIRST_NEG) && above) begin
                     pos_in = '0;
                     loss_in = 1'b0;
                  end
                  if ((phase_ff == PH_DET_NEG) && above) begin
                     pos_in = '0;
                  end
               end
            end
            default: begin
               pos_in = '0;
               loss_in = 1'b1;
            end
         endcase
      end
   end

   assign wr_addr = pos_ff[AW-1:0];
   assign rd_addr = pos_in[AW-1:0];
   assign fill_in = (wr_en && (pos_ff >= fill_ff)) ? pos_ff + 1'b1 : fill_ff;

   acml_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CYCLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s1_sample_ff),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff <= '0;
         fill_ff <= '0;
         cnt_ff <= '0;
         loss_ff <= 1'b1;
         diff_ff <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         loss_ff <= loss_in;
         diff_ff <= diff_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata[SAMPLE_W-1:0];
         s1_ok_ff <= req_tdata[SAMPLE_W];
         fwd_data_ff <= s1_sample_ff;
      end
      if (fire) begin
         rsp_loss_ff <= loss_in;
         rsp_diff_ff <= diff_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(RSP_DATA_W-SAMPLE_W-1)'(0), rsp_diff_ff, rsp_loss_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_P)
      else $error("fill mark beyond store depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= DEPTH_P)
      else $error("position beyond store depth");

   a_idle_loss: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) || (phase_ff == PH_WAIT_NEG) || (phase_ff == PH_WAIT_POS)
      || (phase_ff == PH_FIRST_POS) || (phase_ff == PH_FIRST_NEG) |-> loss_ff)
      else $error("loss cleared before detection");

   a_det_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DET_POS) || (phase_ff == PH_DET_NEG) |-> !loss_ff)
      else $error("loss set while detecting");

   a_write_fills: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> fill_ff > $past(pos_ff))
      else $error("write above fill mark");

endmodule

`default_nettype wire
